// ===== rtl/tect_pkg.sv =====
// Shared types, constants and hash constants of the token counter table.
package tect_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [9:0] REC_BYTES = 10'd400;
  localparam logic [9:0] REC_PAD_MAX = 10'd7;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] REC_BYTES_64 = 64'd400;

  localparam logic [63:0] MIX_ADD = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;

  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_LOST = 2'd1;

  // Work item handed from the front part to the back part.
  typedef struct packed {
    logic        do_count;   // record with a valid size and nonzero token
    logic        look;       // token is nonzero, a lookup is needed
    logic [63:0] token;
    logic [63:0] offset;     // counter snapshot taken after the front update
    logic [63:0] records;
    logic [63:0] lost;
    logic [63:0] errors;
  } job_t;

  // Each 64-bit product of the hash is built from three 32-bit products,
  // one per cycle: low by low, high by low, then low by high and the sum.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_M1_LL,
    ST_M1_HL,
    ST_M1_LH,
    ST_M2_LL,
    ST_M2_HL,
    ST_M2_LH,
    ST_FOLD,
    ST_READ,
    ST_CHECK,
    ST_OUT
  } back_state_e;

endpackage

// ===== rtl/token_event_counter_table.sv =====
// Top level of the token event counter table.
//
//  channel | signals                          | direction
//  in      | valid_i ready_o + 4 fields       | item beats into the block
//  out     | valid_o ready_i + 5 fields       | result beats out of the block
//
// After reset the table is cleared one entry a cycle, all 4096 entries, with ready_o low.
// An item with a nonzero token goes from input beat to result beat through the hash
// product states, the fold of the index, then read and check; each extra probe of the
// single table port repeats read and check. A token of zero skips the lookup.
// The front takes a beat only while the job queue is empty, so one job can wait
// while the back works on the one before it; a stalled output blocks input once
// that job is queued.
module token_event_counter_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  record_size_i,
  input  logic [63:0] token_i,
  input  logic [63:0] lost_count_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] byte_count_o,
  output logic [63:0] record_count_o,
  output logic [63:0] token_count_o,
  output logic [63:0] lost_total_o,
  output logic [63:0] error_count_o
);
  import tect_pkg::*;

  // The queue holds at most one job. That job took its error snapshot before a
  // table error of the job ahead of it could reach the front's counter, so the
  // back carries such an error over to the waiting job when it pops it. Later
  // snapshots see the error through the front's counter.
  logic push, pop, full, empty, err_inc, busy, front_ready;
  job_t job_in, job_out;

  tect_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o(front_ready), .action_i, .record_size_i,
    .token_i, .lost_count_i, .err_inc_i(err_inc), .push_o(push), .job_o(job_in),
    .full_i(full || busy || !empty || pop)
  );

  tect_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(job_out)
  );

  tect_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(job_out), .pop_o(pop),
    .err_inc_o(err_inc), .valid_o, .ready_i, .byte_count_o, .record_count_o,
    .token_count_o, .lost_total_o, .error_count_o, .busy_o(busy)
  );

  assign ready_o = front_ready;

  a_no_ready_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ready_o) else $error("input taken during table clear");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
endmodule

// ===== rtl/tect_ram.sv =====
// Generic single-port RAM with registered read data.
module tect_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== rtl/tect_front.sv =====
// Front part: classifies items and keeps the four scalar counters.
module tect_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [1:0]           action_i,
  input  logic [9:0]           record_size_i,
  input  logic [63:0]          token_i,
  input  logic [63:0]          lost_count_i,
  input  logic                 err_inc_i,
  output logic                 push_o,
  output tect_pkg::job_t       job_o,
  input  logic                 full_i
);
  import tect_pkg::*;

  logic [63:0] offset_q, offset_d, records_q, records_d;
  logic [63:0] lost_q, lost_d, errors_q, errors_d;
  logic        size_ok, accept;
  logic [64:0] lost_sum;
  logic [1:0]  err_n;
  logic [63:0] err_base;

  assign ready_o = !full_i;
  assign accept = valid_i && ready_o;
  assign size_ok = (record_size_i >= REC_BYTES) && (record_size_i <= REC_BYTES + REC_PAD_MAX);
  assign lost_sum = {1'b0, lost_q} + {1'b0, lost_count_i};

  always_comb begin
    offset_d = offset_q;
    records_d = records_q;
    lost_d = lost_q;
    err_n = 2'd0;
    if (accept && action_i == ACT_RECORD) begin
      if (!size_ok) begin
        err_n = 2'd1;
      end else begin
        if (ALL_ONES - offset_q < REC_BYTES_64) begin
          offset_d = ALL_ONES;
          err_n = 2'd1;
        end else begin
          offset_d = offset_q + REC_BYTES_64;
        end
        if (records_q != ALL_ONES) begin
          records_d = records_q + 64'd1;
        end
      end
    end else if (accept && action_i == ACT_LOST) begin
      if (lost_sum[64]) begin
        lost_d = ALL_ONES;
        err_n = 2'd1;
      end else begin
        lost_d = lost_sum[63:0];
      end
    end
    // A table error from the back part lands in the same cycle as a new one.
    err_base = errors_q;
    if (err_inc_i && err_base != ALL_ONES) begin
      err_base = err_base + 64'd1;
    end
    errors_d = err_base;
    if (err_n != 2'd0 && errors_d != ALL_ONES) begin
      errors_d = errors_d + 64'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      records_q <= '0;
      lost_q <= '0;
      errors_q <= '0;
    end else begin
      offset_q <= offset_d;
      records_q <= records_d;
      lost_q <= lost_d;
      errors_q <= errors_d;
    end
  end

  assign push_o = accept;
  always_comb begin
    job_o.do_count = (action_i == ACT_RECORD) && size_ok && (token_i != 64'd0);
    job_o.look = token_i != 64'd0;
    job_o.token = token_i;
    job_o.offset = offset_d;
    job_o.records = records_d;
    job_o.lost = lost_d;
    job_o.errors = errors_d;
  end
endmodule

// ===== rtl/tect_queue.sv =====
// Short FIFO of jobs between the front and the back part.
module tect_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tect_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tect_pkg::job_t data_o
);
  import tect_pkg::*;

  job_t            slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
    end
  end
endmodule

// ===== rtl/tect_back.sv =====
// Back part: clears the table, hashes the token, probes, counts and answers.
module tect_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tect_pkg::job_t job_i,
  output logic           pop_o,
  output logic           err_inc_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [63:0]    byte_count_o,
  output logic [63:0]    record_count_o,
  output logic [63:0]    token_count_o,
  output logic [63:0]    lost_total_o,
  output logic [63:0]    error_count_o,
  output logic           busy_o
);
  import tect_pkg::*;

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [63:0] h_q, h_d, p_q, p_d, cnt_res_q, cnt_res_d;
  logic [31:0] c_q, c_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, mix_x;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] probes_q, probes_d;
  logic [63:0] err_adj_q, err_adj_d;
  logic        carry_q, carry_d;
  logic [64:0] err_total;
  logic        we;
  logic [IDX_W-1:0] addr;
  logic [128:0] wdata, rdata;
  logic        used_r, hit, full_tbl;
  logic [63:0] key_r, count_r;

  // Each entry holds a used bit, its key and its count.
  tect_ram #(.WIDTH(129), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign used_r = rdata[128];
  assign key_r = rdata[127:64];
  assign count_r = rdata[63:0];
  assign hit = used_r && key_r == job_q.token;
  assign full_tbl = probes_q == CNT_W'(TABLE_ENTRIES - 1);
  assign addr = idx_q;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (!empty_i) state_d = job_i.look ? ST_M1_LL : ST_OUT;
      end
      ST_M1_LL: state_d = ST_M1_HL;
      ST_M1_HL: state_d = ST_M1_LH;
      ST_M1_LH: state_d = ST_M2_LL;
      ST_M2_LL: state_d = ST_M2_HL;
      ST_M2_HL: state_d = ST_M2_LH;
      ST_M2_LH: state_d = ST_FOLD;
      ST_FOLD: state_d = ST_READ;
      ST_READ: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!used_r || hit || full_tbl) state_d = ST_OUT;
        else state_d = ST_READ;
      end
      ST_OUT: if (ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    h_d = h_q;
    p_d = p_q;
    c_d = c_q;
    mix_x = '0;
    mul_a = '0;
    mul_b = '0;
    idx_d = idx_q;
    probes_d = probes_q;
    cnt_res_d = cnt_res_q;
    err_adj_d = err_adj_q;
    carry_d = carry_q;
    we = 1'b0;
    wdata = '0;
    err_inc_o = 1'b0;
    pop_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      ST_IDLE: begin
        cnt_res_d = '0;
        probes_d = '0;
        // A table error of the previous job that this job's snapshot missed.
        err_adj_d = {63'd0, carry_q};
        h_d = job_i.token + MIX_ADD;
        pop_o = !empty_i;
        if (!empty_i) carry_d = 1'b0;
      end
      ST_M1_LL: begin
        mix_x = h_q ^ (h_q >> 30);
        h_d = mix_x;
        mul_a = mix_x[31:0];
        mul_b = MIX_MUL1[31:0];
        p_d = mul_p;
      end
      ST_M1_HL: begin
        mul_a = h_q[63:32];
        mul_b = MIX_MUL1[31:0];
        c_d = mul_p[31:0];
      end
      ST_M1_LH: begin
        mul_a = h_q[31:0];
        mul_b = MIX_MUL1[63:32];
        h_d = p_q + {c_q + mul_p[31:0], 32'd0};
      end
      ST_M2_LL: begin
        mix_x = h_q ^ (h_q >> 27);
        h_d = mix_x;
        mul_a = mix_x[31:0];
        mul_b = MIX_MUL2[31:0];
        p_d = mul_p;
      end
      ST_M2_HL: begin
        mul_a = h_q[63:32];
        mul_b = MIX_MUL2[31:0];
        c_d = mul_p[31:0];
      end
      ST_M2_LH: begin
        mul_a = h_q[31:0];
        mul_b = MIX_MUL2[63:32];
        h_d = p_q + {c_q + mul_p[31:0], 32'd0};
      end
      ST_FOLD: idx_d = h_q[IDX_W-1:0] ^ h_q[31 +: IDX_W];
      ST_CHECK: begin
        if (!used_r) begin
          if (job_q.do_count) begin
            we = 1'b1;
            wdata = {1'b1, job_q.token, 64'd1};
            cnt_res_d = 64'd1;
          end
        end else if (hit) begin
          cnt_res_d = count_r;
          if (job_q.do_count) begin
            if (count_r == ALL_ONES) begin
              err_inc_o = 1'b1;
              err_adj_d = err_adj_q + 64'd1;
            end else begin
              we = 1'b1;
              wdata = {1'b1, job_q.token, count_r + 64'd1};
              cnt_res_d = count_r + 64'd1;
            end
          end
        end else if (full_tbl) begin
          if (job_q.do_count) begin
            err_inc_o = 1'b1;
            err_adj_d = err_adj_q + 64'd1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          probes_d = probes_q + 1'b1;
        end
      end
      default: ;
    endcase
    // A job already queued took its snapshot before this error reached the front.
    if (err_inc_o && !empty_i) carry_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      job_q <= job_i;
    end
    h_q <= h_d;
    p_q <= p_d;
    c_q <= c_d;
    cnt_res_q <= cnt_res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q <= '0;
      probes_q <= '0;
      err_adj_q <= '0;
      carry_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      probes_q <= probes_d;
      err_adj_q <= err_adj_d;
      carry_q <= carry_d;
    end
  end

  assign err_total = {1'b0, job_q.errors} + {1'b0, err_adj_q};
  assign valid_o = state_q == ST_OUT;
  assign busy_o = state_q == ST_CLEAR;
  assign byte_count_o = job_q.offset;
  assign record_count_o = job_q.records;
  assign token_count_o = cnt_res_q;
  assign lost_total_o = job_q.lost;
  assign error_count_o = err_total[64] ? ALL_ONES : err_total[63:0];
endmodule

// ===== dv/token_event_counter_table_test.sv =====
// Self-checking testbench for the token event counter table: directed rows, then random traffic.
module token_event_counter_table_test;
  import tect_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The package names only the first two actions, so the other two codes are named here.
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int unsigned RANDOM_BEATS = 2000;
  localparam int unsigned TOKEN_POOL = 48;

  // One input beat.
  typedef struct {
    logic [1:0]  action;
    logic [9:0]  size;
    logic [63:0] token;
    logic [63:0] lost;
  } event_t;

  // One result beat: a snapshot of every counter.
  typedef struct {
    logic [63:0] offset;
    logic [63:0] records;
    logic [63:0] tok_count;
    logic [63:0] lost;
    logic [63:0] errors;
  } snapshot_t;

  // A directed row. Where typed is set, the snapshot is written down by hand.
  typedef struct {
    event_t    ev;
    bit        typed;
    snapshot_t snap;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic [1:0]  action_i;
  logic [9:0]  record_size_i;
  logic [63:0] token_i;
  logic [63:0] lost_count_i;
  logic        valid_o;
  logic        ready_i;
  logic [63:0] byte_count_o;
  logic [63:0] record_count_o;
  logic [63:0] token_count_o;
  logic [63:0] lost_total_o;
  logic [63:0] error_count_o;

  token_event_counter_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .ready_o         (ready_o),
    .action_i        (action_i),
    .record_size_i   (record_size_i),
    .token_i         (token_i),
    .lost_count_i    (lost_count_i),
    .valid_o         (valid_o),
    .ready_i         (ready_i),
    .byte_count_o    (byte_count_o),
    .record_count_o  (record_count_o),
    .token_count_o   (token_count_o),
    .lost_total_o    (lost_total_o),
    .error_count_o   (error_count_o)
  );

  // Shadow copy of the block's state. The table mirrors the hardware layout, so
  // the probe order and the table-full case come out exactly as in the block.
  bit          shadow_used [TABLE_ENTRIES];
  logic [63:0] shadow_key [TABLE_ENTRIES];
  logic [63:0] shadow_count [TABLE_ENTRIES];
  logic [63:0] shadow_offset;
  logic [63:0] shadow_records;
  logic [63:0] shadow_lost;
  logic [63:0] shadow_errors;

  snapshot_t   pending_snaps[$];
  int unsigned fail_count;
  int unsigned beats_sent;
  int unsigned beats_seen;
  int unsigned record_beats;
  int unsigned bad_size_beats;
  int unsigned lost_beats;
  int unsigned query_beats;
  bit          stim_done;
  logic [63:0] token_pool [TOKEN_POOL];

  // The clock runs free; reset is asserted once at the start, then released.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // SplitMix64 finalizer; the 64-bit products simply wrap.
  function automatic logic [63:0] splitmix(logic [63:0] x);
    logic [63:0] z;
    z = x + 64'h9e37_79b9_7f4a_7c15;
    z = (z ^ (z >> 30)) * 64'hbf58_476d_1ce4_e5b9;
    z = (z ^ (z >> 27)) * 64'h94d0_49bb_1331_11eb;
    return z ^ (z >> 31);
  endfunction

  function automatic void bump_errors();
    if (shadow_errors != ALL_ONES) shadow_errors++;
  endfunction

  // Walks the probe chain of a token. Returns the slot holding it, or the first
  // empty slot with found clear, or -1 when the whole table was probed.
  function automatic int probe_slot(logic [63:0] key, output bit found);
    int unsigned idx;
    idx = splitmix(key) % TABLE_ENTRIES;
    found = 1'b0;
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      if (!shadow_used[idx]) return idx;
      if (shadow_key[idx] == key) begin
        found = 1'b1;
        return idx;
      end
      idx = (idx + 1) % TABLE_ENTRIES;
    end
    return -1;
  endfunction

  // Applies one beat to the shadow state and returns the snapshot it must produce.
  function automatic snapshot_t account_event(event_t ev);
    snapshot_t s;
    bit        found;
    int        slot;
    if (ev.action == ACT_RECORD) begin
      if (ev.size < REC_BYTES || ev.size > REC_BYTES + REC_PAD_MAX) begin
        bump_errors();
      end else begin
        if (ALL_ONES - shadow_offset < REC_BYTES_64) begin
          shadow_offset = ALL_ONES;
          bump_errors();
        end else begin
          shadow_offset += REC_BYTES_64;
        end
        if (shadow_records != ALL_ONES) shadow_records++;
        if (ev.token != 64'd0) begin
          slot = probe_slot(ev.token, found);
          if (slot < 0) begin
            bump_errors();
          end else if (!found) begin
            shadow_used[slot] = 1'b1;
            shadow_key[slot] = ev.token;
            shadow_count[slot] = 64'd1;
          end else if (shadow_count[slot] == ALL_ONES) begin
            bump_errors();
          end else begin
            shadow_count[slot]++;
          end
        end
      end
    end else if (ev.action == ACT_LOST) begin
      if (ALL_ONES - shadow_lost < ev.lost) begin
        shadow_lost = ALL_ONES;
        bump_errors();
      end else begin
        shadow_lost += ev.lost;
      end
    end
    // Queries and the spare action change nothing; every action looks up a nonzero token.
    s.tok_count = 64'd0;
    if (ev.token != 64'd0) begin
      slot = probe_slot(ev.token, found);
      if (found) s.tok_count = shadow_count[slot];
    end
    s.offset = shadow_offset;
    s.records = shadow_records;
    s.lost = shadow_lost;
    s.errors = shadow_errors;
    return s;
  endfunction

  function automatic event_t mk(logic [1:0] a, logic [9:0] sz, logic [63:0] t, logic [63:0] l);
    event_t ev;
    ev.action = a;
    ev.size = sz;
    ev.token = t;
    ev.lost = l;
    return ev;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Idle gaps: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random beat. Most beats are well-formed records on a small token pool, so
  // tokens repeat and counts climb; the rest covers every other corner.
  function automatic event_t random_event();
    event_t      ev;
    int unsigned r;
    r = $urandom_range(0, 99);
    ev.token = token_pool[$urandom_range(0, TOKEN_POOL - 1)];
    ev.size = REC_BYTES + 10'($urandom_range(0, int'(REC_PAD_MAX)));
    ev.lost = 64'($urandom_range(0, 1000));
    if (r < 55) begin
      ev.action = ACT_RECORD;
    end else if (r < 65) begin
      ev.action = ACT_RECORD;
      ev.size = 10'($urandom_range(0, 1023));
    end else if (r < 75) begin
      ev.action = ACT_LOST;
      if ($urandom_range(0, 19) == 0) ev.lost = rand64();
    end else if (r < 95) begin
      ev.action = ACT_QUERY;
    end else begin
      ev.action = ACT_SPARE;
    end
    if ($urandom_range(0, 9) == 0) ev.token = rand64();
    if ($urandom_range(0, 19) == 0) ev.token = 64'd0;
    return ev;
  endfunction

  // Offers one beat and waits for it to be taken. Valid stays high across
  // back-to-back beats; it only drops when a gap is inserted first.
  task automatic offer_beat(event_t ev, bit typed, snapshot_t typed_snap);
    snapshot_t   s;
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    action_i <= ev.action;
    record_size_i <= ev.size;
    token_i <= ev.token;
    lost_count_i <= ev.lost;
    do @(posedge clk_i); while (!ready_o);
    s = account_event(ev);
    pending_snaps.push_back(typed ? typed_snap : s);
    beats_sent++;
    if (ev.action == ACT_RECORD) begin
      if (ev.size >= REC_BYTES && ev.size <= REC_BYTES + REC_PAD_MAX) record_beats++;
      else bad_size_beats++;
    end else if (ev.action == ACT_LOST) begin
      lost_beats++;
    end else begin
      query_beats++;
    end
  endtask

  // Stimulus: the directed table first, then random beats.
  initial begin
    row_t      rows[$];
    row_t      row;
    snapshot_t none;
    valid_i = 1'b0;
    action_i = ACT_QUERY;
    record_size_i = '0;
    token_i = '0;
    lost_count_i = '0;
    stim_done = 1'b0;
    fail_count = 0;
    beats_sent = 0;
    beats_seen = 0;
    record_beats = 0;
    bad_size_beats = 0;
    lost_beats = 0;
    query_beats = 0;
    shadow_offset = '0;
    shadow_records = '0;
    shadow_lost = '0;
    shadow_errors = '0;
    none = '{default: 64'd0};
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    foreach (token_pool[i]) token_pool[i] = rand64();
    token_pool[0] = ALL_ONES;
    token_pool[1] = 64'd1;

    // Rows with a typed snapshot: the fresh table, the size edges, token zero.
    row.typed = 1'b1;
    row.ev = mk(ACT_QUERY, 10'd0, 64'd0, 64'd0);
    row.snap = none;
    rows.push_back(row);
    row.ev = mk(ACT_QUERY, 10'd0, ALL_ONES, ALL_ONES);
    rows.push_back(row);
    row.ev = mk(ACT_RECORD, 10'd399, 64'd5, 64'd0);
    row.snap.errors = 64'd1;
    rows.push_back(row);
    row.ev = mk(ACT_RECORD, 10'd408, 64'd5, 64'd0);
    row.snap.errors = 64'd2;
    rows.push_back(row);
    row.ev = mk(ACT_RECORD, 10'd1023, 64'd5, 64'd0);
    row.snap.errors = 64'd3;
    rows.push_back(row);
    row.ev = mk(ACT_RECORD, 10'd400, 64'd0, 64'd0);
    row.snap.offset = 64'd400;
    row.snap.records = 64'd1;
    rows.push_back(row);
    row.ev = mk(ACT_RECORD, 10'd407, ALL_ONES, 64'd0);
    row.snap.offset = 64'd800;
    row.snap.records = 64'd2;
    row.snap.tok_count = 64'd1;
    rows.push_back(row);
    // Remaining rows go through the shadow model.
    row.typed = 1'b0;
    row.ev = mk(ACT_RECORD, 10'd403, ALL_ONES, 64'd0);
    rows.push_back(row);
    row.ev = mk(ACT_RECORD, 10'd400, 64'd1, ALL_ONES);
    rows.push_back(row);
    row.ev = mk(ACT_LOST, 10'd0, 64'd1, 64'd0);
    rows.push_back(row);
    row.ev = mk(ACT_LOST, 10'd0, ALL_ONES, 64'd12345);
    rows.push_back(row);
    row.ev = mk(ACT_LOST, 10'd1023, 64'd0, ALL_ONES);
    rows.push_back(row);
    row.ev = mk(ACT_QUERY, 10'd400, ALL_ONES, ALL_ONES);
    rows.push_back(row);
    row.ev = mk(ACT_SPARE, 10'd400, 64'd1, ALL_ONES);
    rows.push_back(row);
    row.ev = mk(ACT_QUERY, 10'd0, 64'hDEAD_BEEF_0000_0001, 64'd0);
    rows.push_back(row);
    row.ev = mk(ACT_RECORD, 10'd405, 64'h8000_0000_0000_0000, 64'd0);
    rows.push_back(row);

    @(posedge clk_i iff rst_ni);
    foreach (rows[i]) offer_beat(rows[i].ev, rows[i].typed, rows[i].snap);
    for (int unsigned n = 0; n < RANDOM_BEATS; n++) offer_beat(random_event(), 1'b0, none);
    valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: checks each accepted beat, then picks ready for the next cycle.
  // Once, a few hundred beats in, ready is held low for a long stretch so the
  // job queue fills and the block must stall its input.
  initial begin
    snapshot_t   want;
    int unsigned hold_left;
    bit          long_hold_done;
    ready_i = 1'b0;
    hold_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (valid_o && ready_i) begin
        beats_seen++;
        if (pending_snaps.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_snaps.pop_front();
          if (byte_count_o !== want.offset) begin
            $error("byte_count: expected %0h, got %0h", want.offset, byte_count_o);
            fail_count++;
          end
          if (record_count_o !== want.records) begin
            $error("record_count: expected %0h, got %0h", want.records, record_count_o);
            fail_count++;
          end
          if (token_count_o !== want.tok_count) begin
            $error("token_count: expected %0h, got %0h", want.tok_count, token_count_o);
            fail_count++;
          end
          if (lost_total_o !== want.lost) begin
            $error("lost_total: expected %0h, got %0h", want.lost, lost_total_o);
            fail_count++;
          end
          if (error_count_o !== want.errors) begin
            $error("error_count: expected %0h, got %0h", want.errors, error_count_o);
            fail_count++;
          end
        end
      end
      if (!long_hold_done && beats_sent >= 400) begin
        long_hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_i <= 1'b0;
      end else if (beats_sent > 1000 && beats_sent < 1200) begin
        ready_i <= 1'b1;
      end else begin
        ready_i <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // End of run: wait out all expectations, let the block settle, then report.
  initial begin
    @(posedge clk_i iff stim_done);
    while (pending_snaps.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d beats: %0d good records, %0d bad sizes, %0d lost reports, %0d queries.",
             beats_sent, record_beats, bad_size_beats, lost_beats, query_beats);
    $display("Checked %0d result beats, final error counter %0h.", beats_seen, shadow_errors);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the table clear.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== token_event_counter_table.f =====
rtl/tect_pkg.sv
rtl/tect_ram.sv
rtl/tect_front.sv
rtl/tect_queue.sv
rtl/tect_back.sv
rtl/token_event_counter_table.sv
dv/token_event_counter_table_test.sv
